// ===== src/ctc_pkg.sv =====
// ----------------------------------------------------------------------------
// ctc_pkg
// Shared types, constants and character class helpers for the C-subset
// token classifier.
// ----------------------------------------------------------------------------
package ctc_pkg;

  localparam int MAX_TOKEN = 100;
  localparam int LINE_MAX  = 1024;

  localparam int NKW       = 12;
  localparam int KIND_W    = 3;
  localparam int KWN_W     = 4;
  localparam int START_W   = 10;
  localparam int LEN_OUT_W = 7;
  localparam int TOTAL_W   = 11;

  localparam logic [KWN_W-1:0]   KW_NONE   = 4'd12;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 11'd2047;

  typedef enum logic [KIND_W-1:0] {
    KIND_KEYWORD = 3'd0,
    KIND_IDENT   = 3'd1,
    KIND_NUMBER  = 3'd2,
    KIND_OPER    = 3'd3,
    KIND_DELIM   = 3'd4,
    KIND_ERROR   = 3'd5,
    KIND_END     = 3'd6
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic [KWN_W-1:0]       kwn;
    logic [START_W-1:0]     start;
    logic [LEN_OUT_W-1:0]   len;
    logic                   clip;
    logic [7:0]             lead;
    logic                   two;
    logic [TOTAL_W-1:0]     total;
  } rec_t;

  // Keyword text, right aligned: first character sits in the highest used byte.
  localparam logic [63:0] KW_STR [NKW] = '{
    64'("if"), 64'("else"), 64'("while"), 64'("for"), 64'("do"), 64'("break"),
    64'("continue"), 64'("return"), 64'("int"), 64'("float"), 64'("char"),
    64'("void")
  };
  localparam logic [3:0] KW_LEN [NKW] = '{
    4'd2, 4'd4, 4'd5, 4'd3, 4'd2, 4'd5, 4'd8, 4'd6, 4'd3, 4'd5, 4'd4, 4'd4
  };

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c == "_");
  endfunction

  function automatic logic is_pairable(logic [7:0] c);
    return (c == "=") || (c == "<") || (c == ">") || (c == "!");
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return is_pairable(c) || (c == "+") || (c == "-") || (c == "*") || (c == "/");
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == "(") || (c == ")") || (c == ";") || (c == "{") || (c == "}") ||
           (c == ",");
  endfunction

  // Character idx of keyword k equals c.
  function automatic logic kw_char_ok(int k, logic [7:0] idx, logic [7:0] c);
    logic       in_rng;
    logic [7:0] b;
    logic [5:0] sh;
    in_rng = idx < 8'(KW_LEN[k]);
    sh     = '0;
    if (in_rng) begin
      sh = 6'(8 * (int'(KW_LEN[k]) - 1 - int'(idx)));
    end
    b = 8'(KW_STR[k] >> sh);
    return in_rng && (b == c);
  endfunction

  function automatic logic [KWN_W-1:0] kw_find(logic [NKW-1:0] mask, logic [7:0] len,
                                               logic clip);
    logic [KWN_W-1:0] kwn;
    kwn = KW_NONE;
    for (int k = 0; k < NKW; k++) begin
      if (!clip && mask[k] && (len == 8'(KW_LEN[k]))) begin
        kwn = KWN_W'(k);
      end
    end
    return kwn;
  endfunction

  function automatic logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] tot);
    return (tot < TOTAL_MAX) ? tot + 11'd1 : tot;
  endfunction

endpackage

// ===== src/ctc_char_if.sv =====
// ----------------------------------------------------------------------------
// ctc_char_if
// Character channel: one source byte per item, with the end-of-line mark.
// ----------------------------------------------------------------------------
interface ctc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink   (input valid, input ch, input line_end, output ready);
endinterface

// ===== src/ctc_token_if.sv =====
// ----------------------------------------------------------------------------
// ctc_token_if
// Token channel: one token record or end record per item.
// ----------------------------------------------------------------------------
interface ctc_token_if;
  logic                            valid;
  logic                            ready;
  logic [ctc_pkg::KIND_W-1:0]      token_kind;
  logic [ctc_pkg::KWN_W-1:0]       keyword_number;
  logic [ctc_pkg::START_W-1:0]     token_start;
  logic [ctc_pkg::LEN_OUT_W-1:0]   token_length;
  logic                            length_clipped;
  logic [7:0]                      lead_char;
  logic                            two_char_op;
  logic [ctc_pkg::TOTAL_W-1:0]     tokens_so_far;
  logic                            run_last;

  modport source (output valid, output token_kind, output keyword_number,
                  output token_start, output token_length, output length_clipped,
                  output lead_char, output two_char_op, output tokens_so_far,
                  output run_last, input ready);
  modport sink   (input valid, input token_kind, input keyword_number,
                  input token_start, input token_length, input length_clipped,
                  input lead_char, input two_char_op, input tokens_so_far,
                  input run_last, output ready);
endinterface

// ===== src/c_subset_token_classifier.sv =====
// ----------------------------------------------------------------------------
// c_subset_token_classifier
// Splits a source line, one character per item, into classified tokens.
// ----------------------------------------------------------------------------
// Usage:
//   char_i carries one byte per item plus line_end on the last byte of a line.
//   token_o gives token records in line order; each character item yields
//   zero to three records, and run_last marks the last record of that item.
//   The item with line_end flushes a pending token and adds an end record
//   carrying the line's token count, then the line state restarts.
// Latency: the first record of an item is visible on token_o the cycle after the
//   item is accepted (when the output queue is empty).
// Throughput: one character per cycle while token_o.ready is high and each
//   character yields at most one record; else the output port, one record
//   per cycle, sets the pace. Records are grouped per item in a two-entry
//   queue, so a new character is taken while an earlier group waits to drain.
// Stall: when token_o.ready is low the queue fills and char_i.ready drops
//   once both group entries hold records.
// Reset: line state returns to idle, count zero, queue empty.
// ----------------------------------------------------------------------------
module c_subset_token_classifier #(
  parameter int MaxToken = ctc_pkg::MAX_TOKEN,
  parameter int LineMax  = ctc_pkg::LINE_MAX
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ctc_char_if.sink            char_i,
  ctc_token_if.source         token_o
);

  localparam int LenW = $clog2(MaxToken + 1);
  localparam int PosW = $clog2(LineMax);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUM,
    MODE_OP
  } mode_e;

  typedef struct packed {
    logic [LenW-1:0]         len;
    logic                    clip;
    logic [ctc_pkg::NKW-1:0] mask;
  } ext_t;

  typedef struct packed {
    ctc_pkg::rec_t [2:0] rec;
    logic [1:0]          n;
  } group_t;

  localparam ext_t EXT_CLR = '{len: '0, clip: 1'b0, mask: '1};

  // Add one character to the pending token and narrow the keyword candidates; at MaxToken, mark it clipped instead.
  function automatic ext_t extend_tok(ext_t s, logic [7:0] c);
    ext_t r;
    r = s;
    if (s.len < LenW'(MaxToken)) begin
      for (int k = 0; k < ctc_pkg::NKW; k++) begin
        if (!ctc_pkg::kw_char_ok(k, 8'(s.len), c)) begin
          r.mask[k] = 1'b0;
        end
      end
      r.len = s.len + LenW'(1);
    end else begin
      r.clip = 1'b1;
      r.mask = '0;
    end
    return r;
  endfunction

  function automatic ctc_pkg::rec_t flush_rec(mode_e m, logic [ctc_pkg::START_W-1:0] st,
                                              ext_t e, logic [7:0] ld);
    ctc_pkg::rec_t r;
    r       = '0;
    r.start = st;
    r.lead  = ld;
    r.kwn   = ctc_pkg::KW_NONE;
    case (m)
      MODE_IDENT: begin
        r.kwn  = ctc_pkg::kw_find(e.mask, 8'(e.len), e.clip);
        r.kind = (r.kwn != ctc_pkg::KW_NONE) ? ctc_pkg::KIND_KEYWORD
                                             : ctc_pkg::KIND_IDENT;
        r.len  = ctc_pkg::LEN_OUT_W'(e.len);
        r.clip = e.clip;
      end
      MODE_NUM: begin
        r.kind = ctc_pkg::KIND_NUMBER;
        r.len  = ctc_pkg::LEN_OUT_W'(e.len);
        r.clip = e.clip;
      end
      default: begin
        r.kind = ctc_pkg::KIND_OPER;
        r.len  = 7'd1;
      end
    endcase
    return r;
  endfunction

  function automatic ctc_pkg::rec_t char_rec(ctc_pkg::kind_e k,
                                             logic [ctc_pkg::START_W-1:0] st,
                                             logic [7:0] c);
    ctc_pkg::rec_t r;
    r       = '0;
    r.kind  = k;
    r.kwn   = ctc_pkg::KW_NONE;
    r.start = st;
    r.len   = 7'd1;
    r.lead  = c;
    return r;
  endfunction

  // Line state
  mode_e                            mode_q, mode_d;
  ext_t                             ext_q, ext_d;
  logic [7:0]                       lead_q, lead_d;
  logic [ctc_pkg::START_W-1:0]      start_q, start_d;
  logic [PosW-1:0]                  pos_q, pos_d;
  logic [ctc_pkg::TOTAL_W-1:0]      total_q, total_d;

  // Records of the current item
  ctc_pkg::rec_t [2:0]              recs;
  logic [1:0]                       nrec;
  ctc_pkg::rec_t                    r;
  logic                             used;
  logic [7:0]                       c;
  logic [ctc_pkg::START_W-1:0]      pos_s;

  // Output group queue
  group_t                           grp_q [2];
  logic                             wr_q, rd_q;
  logic [1:0]                       cnt_q;
  logic [1:0]                       slot_q;
  group_t                           head;
  ctc_pkg::rec_t                    cur;
  logic                             in_fire, out_fire, push, pop, run_last;

  assign c     = char_i.ch;
  assign pos_s = ctc_pkg::START_W'(pos_q);

  always_comb begin
    mode_d  = mode_q;
    ext_d   = ext_q;
    lead_d  = lead_q;
    start_d = start_q;
    total_d = total_q;
    recs    = '0;
    nrec    = 2'd0;
    r       = '0;
    used    = 1'b0;

    // Pending token: continue it or close it
    unique case (mode_q) inside
      MODE_IDENT, MODE_NUM: begin
        if (ctc_pkg::is_digit(c) || (mode_q == MODE_IDENT && ctc_pkg::is_alpha(c))) begin
          ext_d = extend_tok(ext_q, c);
          used  = 1'b1;
        end else begin
          r          = flush_rec(mode_q, start_q, ext_q, lead_q);
          total_d    = ctc_pkg::bump(total_d);
          r.total    = total_d;
          recs[nrec] = r;
          nrec       = nrec + 2'd1;
          mode_d     = MODE_IDLE;
          ext_d      = EXT_CLR;
        end
      end
      MODE_OP: begin
        r = flush_rec(mode_q, start_q, ext_q, lead_q);
        if (c == "=") begin
          r.len = 7'd2;
          r.two = 1'b1;
          used  = 1'b1;
        end else begin
          ext_d = EXT_CLR;
        end
        total_d    = ctc_pkg::bump(total_d);
        r.total    = total_d;
        recs[nrec] = r;
        nrec       = nrec + 2'd1;
        mode_d     = MODE_IDLE;
      end
      MODE_IDLE: begin
      end
    endcase

    // Character not absorbed: start a token or emit a one-character one
    if (!used && !ctc_pkg::is_space(c)) begin
      if (ctc_pkg::is_alpha(c) || ctc_pkg::is_digit(c) || ctc_pkg::is_pairable(c)) begin
        mode_d  = ctc_pkg::is_alpha(c) ? MODE_IDENT :
                  ctc_pkg::is_digit(c) ? MODE_NUM : MODE_OP;
        start_d = pos_s;
        lead_d  = c;
        ext_d   = ctc_pkg::is_pairable(c) ? EXT_CLR : extend_tok(EXT_CLR, c);
      end else begin
        r = char_rec(ctc_pkg::is_op(c)    ? ctc_pkg::KIND_OPER  :
                     ctc_pkg::is_delim(c) ? ctc_pkg::KIND_DELIM : ctc_pkg::KIND_ERROR,
                     pos_s, c);
        total_d    = ctc_pkg::bump(total_d);
        r.total    = total_d;
        recs[nrec] = r;
        nrec       = nrec + 2'd1;
      end
    end

    pos_d = (pos_q < PosW'(LineMax - 1)) ? pos_q + PosW'(1) : pos_q;

    // End of line: flush, end record, back to reset state
    if (char_i.line_end) begin
      if (mode_d != MODE_IDLE) begin
        r          = flush_rec(mode_d, start_d, ext_d, lead_d);
        total_d    = ctc_pkg::bump(total_d);
        r.total    = total_d;
        recs[nrec] = r;
        nrec       = nrec + 2'd1;
      end
      r          = '0;
      r.kind     = ctc_pkg::KIND_END;
      r.kwn      = ctc_pkg::KW_NONE;
      r.total    = total_d;
      recs[nrec] = r;
      nrec       = nrec + 2'd1;
      mode_d     = MODE_IDLE;
      ext_d      = EXT_CLR;
      lead_d     = '0;
      start_d    = '0;
      pos_d      = '0;
      total_d    = '0;
    end
  end

  assign in_fire  = char_i.valid && char_i.ready;
  assign out_fire = token_o.valid && token_o.ready;
  assign push     = in_fire && (nrec != 2'd0);
  assign head     = grp_q[rd_q];
  assign cur      = head.rec[slot_q];
  assign run_last = (slot_q == head.n - 2'd1);
  assign pop      = out_fire && run_last;

  assign char_i.ready = (cnt_q != 2'd2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      ext_q   <= EXT_CLR;
      lead_q  <= '0;
      start_q <= '0;
      pos_q   <= '0;
      total_q <= '0;
    end else if (in_fire) begin
      mode_q  <= mode_d;
      ext_q   <= ext_d;
      lead_q  <= lead_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      cnt_q  <= 2'd0;
      slot_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q   <= ~rd_q;
        slot_q <= 2'd0;
      end else if (out_fire) begin
        slot_q <= slot_q + 2'd1;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  // Group payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (push) begin
      grp_q[wr_q] <= '{rec: recs, n: nrec};
    end
  end

  assign token_o.valid          = (cnt_q != 2'd0);
  assign token_o.token_kind     = cur.kind;
  assign token_o.keyword_number = cur.kwn;
  assign token_o.token_start    = cur.start;
  assign token_o.token_length   = cur.len;
  assign token_o.length_clipped = cur.clip;
  assign token_o.lead_char      = cur.lead;
  assign token_o.two_char_op    = cur.two;
  assign token_o.tokens_so_far  = cur.total;
  assign token_o.run_last       = run_last;

endmodule
